### rtl/core/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types, constants and opcode classification for the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtm_pkg;

   localparam int ADDR_BITS = 16;
   localparam int DATA_W    = 16;
   localparam int FUNC_W    = 6;
   localparam int KIND_W    = 2;
   localparam int SHIFT_LIM = 16;
   localparam logic [DATA_W-1:0] CHAR_MAX_CODE = 16'h00FF;
   localparam logic [FUNC_W-1:0] FUNC_LAST     = 6'd41;

   // console output kinds
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NUM  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHAR = 2'd2;

   // opcode pairs, index is func >> 1
   localparam logic [4:0] PAIR_ADD  = 5'd0;
   localparam logic [4:0] PAIR_SUB  = 5'd1;
   localparam logic [4:0] PAIR_MUL  = 5'd2;
   localparam logic [4:0] PAIR_DIV  = 5'd3;
   localparam logic [4:0] PAIR_SHL  = 5'd4;
   localparam logic [4:0] PAIR_SHR  = 5'd5;
   localparam logic [4:0] PAIR_AND  = 5'd6;
   localparam logic [4:0] PAIR_OR   = 5'd7;
   localparam logic [4:0] PAIR_NOT  = 5'd8;
   localparam logic [4:0] PAIR_XOR  = 5'd9;
   localparam logic [4:0] PAIR_JMP  = 5'd10;
   localparam logic [4:0] PAIR_EQ   = 5'd11;
   localparam logic [4:0] PAIR_GT   = 5'd12;
   localparam logic [4:0] PAIR_GE   = 5'd13;
   localparam logic [4:0] PAIR_LT   = 5'd14;
   localparam logic [4:0] PAIR_LE   = 5'd15;
   localparam logic [4:0] PAIR_MOVE = 5'd16;
   localparam logic [4:0] PAIR_INW  = 5'd17;
   localparam logic [4:0] PAIR_INC  = 5'd18;
   localparam logic [4:0] PAIR_OUTN = 5'd19;
   localparam logic [4:0] PAIR_OUTC = 5'd20;

   typedef enum logic [4:0] {
      CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV, CLS_SHL, CLS_SHR, CLS_AND, CLS_OR,
      CLS_NOT, CLS_XOR, CLS_JMP, CLS_EQ, CLS_GT, CLS_GE, CLS_LT, CLS_LE,
      CLS_MOVE, CLS_IN, CLS_OUTN, CLS_OUTC, CLS_NOP
   } op_class_type;

   typedef struct packed {
      op_class_type      cls;
      logic              imm;
      logic [DATA_W-1:0] a1;
      logic [DATA_W-1:0] a2;
      logic [DATA_W-1:0] con;
   } item_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } back_ctl_type;

   function automatic op_class_type classify(input logic [FUNC_W-1:0] func);
      op_class_type cls;
      logic         imm;
      imm = func[0];
      cls = CLS_NOP;
      if (func <= FUNC_LAST) begin
         case (func[FUNC_W-1:1])
            PAIR_ADD:  cls = CLS_ADD;
            PAIR_SUB:  cls = CLS_SUB;
            PAIR_MUL:  cls = CLS_MUL;
            PAIR_DIV:  cls = CLS_DIV;
            PAIR_SHL:  cls = CLS_SHL;
            PAIR_SHR:  cls = CLS_SHR;
            PAIR_AND:  cls = CLS_AND;
            PAIR_OR:   cls = CLS_OR;
            PAIR_NOT:  cls = imm ? CLS_NOP : CLS_NOT;
            PAIR_XOR:  cls = CLS_XOR;
            PAIR_JMP:  cls = CLS_JMP;
            PAIR_EQ:   cls = CLS_EQ;
            PAIR_GT:   cls = CLS_GT;
            PAIR_GE:   cls = CLS_GE;
            PAIR_LT:   cls = CLS_LT;
            PAIR_LE:   cls = CLS_LE;
            PAIR_MOVE: cls = CLS_MOVE;
            PAIR_INW:  cls = imm ? CLS_NOP : CLS_IN;
            PAIR_INC:  cls = imm ? CLS_NOP : CLS_IN;
            PAIR_OUTN: cls = CLS_OUTN;
            PAIR_OUTC: cls = CLS_OUTC;
            default:   cls = CLS_NOP;
         endcase
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

### rtl/core/mtm_if.sv
// ----------------------------------------------------------------------------
// mtm channel interfaces
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtm_req_if;
   logic                          valid;
   logic                          ready;
   logic [mtm_pkg::FUNC_W-1:0]    func;
   logic [mtm_pkg::DATA_W-1:0]    first_operand;
   logic [mtm_pkg::DATA_W-1:0]    second_operand;
   logic [mtm_pkg::DATA_W-1:0]    console_value;

   modport source (output valid, func, first_operand, second_operand, console_value,
                   input ready);
   modport sink (input valid, func, first_operand, second_operand, console_value,
                 output ready);
endinterface

interface mtm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mtm_pkg::KIND_W-1:0]    out_kind;
   logic [mtm_pkg::DATA_W-1:0]    out_value;
   logic                          jump_taken;
   logic [mtm_pkg::DATA_W-1:0]    jump_target;
   logic                          cond_flag;

   modport source (output valid, out_kind, out_value, jump_taken, jump_target, cond_flag,
                   input ready);
   modport sink (input valid, out_kind, out_value, jump_taken, jump_target, cond_flag,
                 output ready);
endinterface

`default_nettype wire

### rtl/core/mtm_front.sv
// ----------------------------------------------------------------------------
// mtm_front
// Accepts instruction items, decodes the opcode class and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module mtm_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mtm_req_if.sink                    req_ch,
   input  wire mtm_pkg::back_ctl_type ctl,
   output mtm_pkg::item_type          q_item,
   output logic                       q_valid
);

   mtm_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;
   mtm_pkg::item_type new_item;

   always_comb begin
      new_item.cls  = mtm_pkg::classify(req_ch.func);
      new_item.imm  = req_ch.func[0];
      new_item.a1   = req_ch.first_operand;
      new_item.a2   = req_ch.second_operand;
      new_item.con  = req_ch.console_value;
   end

   // hold off items until the memory clearing pass is over
   assign req_ch.ready = ctl.init_done && (count_ff != 2'd2);
   assign push    = req_ch.valid && req_ch.ready;
   assign pop     = ctl.pop && (count_ff != 2'd0);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mtm_div.sv
// ----------------------------------------------------------------------------
// mtm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtm_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [mtm_pkg::DATA_W-1:0] dividend,
   input  wire logic [mtm_pkg::DATA_W-1:0] divisor,
   output logic                            done,
   output logic [mtm_pkg::DATA_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(mtm_pkg::DATA_W);

   logic                       busy_ff;
   logic                       done_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [mtm_pkg::DATA_W-1:0] rem_ff;
   logic [mtm_pkg::DATA_W-1:0] quo_ff;
   logic [mtm_pkg::DATA_W-1:0] dvs_ff;
   logic [mtm_pkg::DATA_W:0]   shifted;
   logic [mtm_pkg::DATA_W:0]   diff;
   logic                       fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[mtm_pkg::DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[mtm_pkg::DATA_W-1:0] : shifted[mtm_pkg::DATA_W-1:0];
            quo_ff <= {quo_ff[mtm_pkg::DATA_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(mtm_pkg::DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/core/mtm_back.sv
// ----------------------------------------------------------------------------
// mtm_back
// Clears data memory, then executes queued items and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mtm_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mtm_pkg::item_type     q_item,
   input  wire logic                  q_valid,
   output mtm_pkg::back_ctl_type      ctl,
   mtm_rsp_if.source                  rsp_ch
);

   localparam int AW = mtm_pkg::ADDR_BITS;
   localparam int DW = mtm_pkg::DATA_W;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_DIV} state_type;

   logic [DW-1:0]     mem_ff [2**AW];
   state_type         state_ff;
   logic [AW-1:0]     clr_ff;
   mtm_pkg::item_type cur_ff;
   logic [DW-1:0]     d_rd_ff;
   logic [DW-1:0]     s_rd_ff;
   logic              flag_ff;
   logic              out_valid_ff;
   logic [mtm_pkg::KIND_W-1:0] kind_ff;
   logic [DW-1:0]     value_ff;
   logic              jt_ff;
   logic [DW-1:0]     tgt_ff;

   logic              start;
   logic              out_free;
   logic              out_set;
   logic [DW-1:0]     d;
   logic [DW-1:0]     s;
   logic [2*DW-1:0]   prod;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DW-1:0]     wr_data;
   logic [DW-1:0]     alu;
   logic              alu_wr;
   logic              div_start;
   logic              div_done;
   logic [DW-1:0]     div_quo;
   logic [DW-1:0]     out_v;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign start    = (state_ff == ST_IDLE) && q_valid && out_free;
   assign ctl      = '{pop: start, init_done: (state_ff != ST_CLEAR)};

   assign d    = d_rd_ff;
   assign s    = cur_ff.imm ? cur_ff.a2 : s_rd_ff;
   assign prod = d * s;
   assign out_v = cur_ff.imm ? cur_ff.a1 : d;
   assign div_start = (state_ff == ST_EXEC) && (cur_ff.cls == mtm_pkg::CLS_DIV) && (s != '0);

   // result is ready at the end of execute, or when the divider finishes
   assign out_set = ((state_ff == ST_EXEC) && !div_start) ||
                    ((state_ff == ST_DIV) && div_done);

   always_comb begin
      alu    = '0;
      alu_wr = 1'b1;
      case (cur_ff.cls)
         mtm_pkg::CLS_ADD:  alu = d + s;
         mtm_pkg::CLS_SUB:  alu = d - s;
         mtm_pkg::CLS_MUL:  alu = prod[DW-1:0];
         mtm_pkg::CLS_DIV:  alu = '0;
         mtm_pkg::CLS_SHL:  alu = (s < DW'(mtm_pkg::SHIFT_LIM)) ? (d << s[3:0]) : '0;
         mtm_pkg::CLS_SHR:  alu = (s < DW'(mtm_pkg::SHIFT_LIM)) ? (d >> s[3:0]) : '0;
         mtm_pkg::CLS_AND:  alu = d & s;
         mtm_pkg::CLS_OR:   alu = d | s;
         mtm_pkg::CLS_NOT:  alu = ~d;
         mtm_pkg::CLS_XOR:  alu = d ^ s;
         mtm_pkg::CLS_MOVE: alu = s;
         mtm_pkg::CLS_IN:   alu = cur_ff.con;
         default:           alu_wr = 1'b0;
      endcase
   end

   // single write port shared by the clearing pass and execution
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff.a1[AW-1:0];
      wr_data = alu;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_EXEC: begin
            wr_en = alu_wr && !div_start;
         end
         ST_DIV: begin
            wr_en   = div_done;
            wr_data = div_quo;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (start) begin
         d_rd_ff <= mem_ff[q_item.a1[AW-1:0]];
         s_rd_ff <= mem_ff[q_item.a2[AW-1:0]];
         cur_ff  <= q_item;
      end
   end

   mtm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (d),
      .divisor  (s),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         kind_ff      <= mtm_pkg::KIND_NONE;
         value_ff     <= '0;
         jt_ff        <= 1'b0;
         tgt_ff       <= '0;
      end else begin
         if (out_set) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == {AW{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               kind_ff  <= mtm_pkg::KIND_NONE;
               value_ff <= '0;
               jt_ff    <= 1'b0;
               tgt_ff   <= '0;
               case (cur_ff.cls)
                  mtm_pkg::CLS_EQ: flag_ff <= (d == s);
                  mtm_pkg::CLS_GT: flag_ff <= (d > s);
                  mtm_pkg::CLS_GE: flag_ff <= (d >= s);
                  mtm_pkg::CLS_LT: flag_ff <= (d < s);
                  mtm_pkg::CLS_LE: flag_ff <= (d <= s);
                  mtm_pkg::CLS_JMP: begin
                     if (flag_ff) begin
                        jt_ff   <= 1'b1;
                        tgt_ff  <= out_v;
                        flag_ff <= 1'b0;
                     end
                  end
                  mtm_pkg::CLS_OUTN: begin
                     kind_ff  <= mtm_pkg::KIND_NUM;
                     value_ff <= out_v;
                  end
                  mtm_pkg::CLS_OUTC: begin
                     if (out_v <= mtm_pkg::CHAR_MAX_CODE) begin
                        kind_ff  <= mtm_pkg::KIND_CHAR;
                        value_ff <= out_v;
                     end
                  end
                  default: begin
                  end
               endcase
               if (div_start) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.out_kind    = kind_ff;
   assign rsp_ch.out_value   = value_ff;
   assign rsp_ch.jump_taken  = jt_ff;
   assign rsp_ch.jump_target = tgt_ff;
   assign rsp_ch.cond_flag   = flag_ff;

endmodule

`default_nettype wire

### rtl/core/mem_to_mem_instruction_execute.sv
// ----------------------------------------------------------------------------
// mem_to_mem_instruction_execute
// Execute unit of a 16-bit memory-to-memory machine.
// ----------------------------------------------------------------------------
// After reset the unit clears its 2^ADDR_BITS-word data memory one word per
// cycle and takes no item until then. Afterwards each item reads both operands
// from memory in one read step, then executes and writes back in a second
// step; a divide with a nonzero divisor then waits in a divide state for the
// 16-step bit-serial divider. One result item is produced per instruction
// item, held in an output register while the next item is queued.
`default_nettype none

module mem_to_mem_instruction_execute (
   input  wire logic clock,
   input  wire logic reset,
   mtm_req_if.sink   req_ch,
   mtm_rsp_if.source rsp_ch
);

   mtm_pkg::item_type     q_item;
   logic                  q_valid;
   mtm_pkg::back_ctl_type ctl;

   mtm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .ctl     (ctl),
      .q_item  (q_item),
      .q_valid (q_valid)
   );

   mtm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_item  (q_item),
      .q_valid (q_valid),
      .ctl     (ctl),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire
